[rtl/akf_pkg.sv]
// Package for the angle and gyro bias Kalman filter.
// Holds field widths, register indexes, reset values, the noise struct
// and the saturation helpers. Depends on nothing.
package akf_pkg;

    localparam int unsigned ANGLE_W = 32;
    localparam int unsigned DT_W    = 16;
    localparam int unsigned NOISE_W = 31;
    localparam int unsigned WIDE_W  = 72;
    localparam int unsigned ADDR_W  = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_Q_ANGLE = 2'd0;
    localparam logic [1:0] REG_Q_BIAS  = 2'd1;
    localparam logic [1:0] REG_R_MEAS  = 2'd2;

    // Reset values of the noise registers, unsigned Q1.30.
    localparam logic [NOISE_W-1:0] RESET_Q_ANGLE = 31'd1073742;
    localparam logic [NOISE_W-1:0] RESET_Q_BIAS  = 31'd3221225;
    localparam logic [NOISE_W-1:0] RESET_R_MEAS  = 31'd32212255;

    typedef struct packed {
        logic [NOISE_W-1:0] q_angle;
        logic [NOISE_W-1:0] q_bias;
        logic [NOISE_W-1:0] r_meas;
    } t_noise;

    // Sign-extend a 32-bit word to the wide working format.
    function automatic logic signed [WIDE_W-1:0] sx72(input logic [31:0] v);
        return {{(WIDE_W-32){v[31]}}, v};
    endfunction

    // Clamp a wide signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > 72'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -72'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

[rtl/akf_if.sv]
// Channel interfaces for the filter: one carries a sample word in,
// the other a result word out. Depends on akf_pkg for the field widths.
interface akf_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [akf_pkg::ANGLE_W-1:0] measured_angle;
    logic signed [akf_pkg::ANGLE_W-1:0] measured_rate;
    logic        [akf_pkg::DT_W-1:0]    time_step;

    modport source (output valid, measured_angle, measured_rate, time_step, input ready);
    modport sink   (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

interface akf_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [akf_pkg::ANGLE_W-1:0] angle_estimate;
    logic signed [akf_pkg::ANGLE_W-1:0] corrected_rate;

    modport source (output valid, angle_estimate, corrected_rate, input ready);
    modport sink   (input valid, angle_estimate, corrected_rate, output ready);
endinterface

[rtl/akf_cfg.sv]
// APB-style register block holding the three noise registers.
// Depends on akf_pkg for the register indexes, reset values and struct.
module akf_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [akf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output akf_pkg::t_noise             o_noise
);

    akf_pkg::t_noise r_noise;

    assign pready  = 1'b1;
    assign o_noise = r_noise;

    // Register writes in the access phase; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise.q_angle <= akf_pkg::RESET_Q_ANGLE;
            r_noise.q_bias  <= akf_pkg::RESET_Q_BIAS;
            r_noise.r_meas  <= akf_pkg::RESET_R_MEAS;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                akf_pkg::REG_Q_ANGLE: r_noise.q_angle <= pwdata[30:0];
                akf_pkg::REG_Q_BIAS:  r_noise.q_bias  <= pwdata[30:0];
                akf_pkg::REG_R_MEAS:  r_noise.r_meas  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (paddr[3:2])
            akf_pkg::REG_Q_ANGLE: prdata = {1'b0, r_noise.q_angle};
            akf_pkg::REG_Q_BIAS:  prdata = {1'b0, r_noise.q_bias};
            akf_pkg::REG_R_MEAS:  prdata = {1'b0, r_noise.r_meas};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

[rtl/akf_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on nothing; the sequencer in the top level drives its operands.
module akf_mul (
    input  logic               i_clk,
    input  logic signed [35:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [68:0] o_p
);

    logic signed [68:0] r_p;

    // One product per cycle, registered before use.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[rtl/akf_div.sv]
// Serial restoring divider for the Kalman gains: num * 2^30 / den,
// truncated toward zero and saturated to 32 bits, one quotient bit a cycle.
module akf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic        [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_q
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [30:0] r_q;
    logic        r_neg;
    logic        r_ovf;
    logic [31:0] w_mag;
    logic [33:0] w_diff;
    logic        w_bit;
    logic [31:0] w_rest;

    assign w_mag  = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_diff = {1'b0, r_rem} - {2'b00, r_den};
    assign w_bit  = !w_diff[33];
    assign w_rest = w_bit ? w_diff[31:0] : r_rem[31:0];

    // Load on start, then one compare and subtract per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, w_mag};
            r_den <= i_den;
            r_neg <= i_num[31];
            // The quotient needs more than 31 bits when |num| >= 2 * den.
            r_ovf <= {1'b0, w_mag} >= {i_den, 1'b0};
            r_q   <= 31'd0;
        end else if (r_busy) begin
            r_rem <= {w_rest, 1'b0};
            r_q   <= {r_q[29:0], w_bit};
        end
    end

    // Sign and saturation of the final quotient.
    always_comb begin
        if (r_ovf) begin
            o_q = r_neg ? 32'sh80000000 : 32'sh7fffffff;
        end else if (r_neg) begin
            o_q = -$signed({1'b0, r_q});
        end else begin
            o_q = $signed({1'b0, r_q});
        end
    end

    assign o_done = r_done;

endmodule

[rtl/angle_bias_kalman_filter.sv]
// Two-state Kalman filter for a tilt angle and gyro bias, Q16.16 / Q2.30.
// Each word runs ten multiply steps (ST_MUL, then ST_WB) on the shared multiplier
// plus two serial gain divisions; the divisions are skipped when the innovation
// variance is not positive. A new word is taken only after the result word leaves.
// Reset (synchronous, active low) clears state and loads the default noise values.
module angle_bias_kalman_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    akf_in_if.sink                      i_in,
    akf_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [akf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_WB     = 6'b000100,
        ST_DGO    = 6'b001000,
        ST_DWAIT  = 6'b010000,
        ST_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [3:0]         r_step;
    logic               r_dsel;
    logic [31:0]        r_z, r_rate, r_ang, r_bias, r_y, r_k0, r_k1, r_dtp11;
    logic [15:0]        r_dt;
    logic [31:0]        r_cov00, r_cov01, r_cov10, r_cov11;
    logic [31:0]        r_w00, r_w01, r_w10, r_w11;

    akf_pkg::t_noise    w_noise;
    logic signed [35:0] w_a;
    logic signed [32:0] w_b;
    logic signed [68:0] w_p;
    logic signed [71:0] w_pw, w_sh16, w_sh30;
    logic signed [35:0] w_inner;
    logic signed [33:0] w_s;
    logic               w_s_pos;
    logic               w_dstart, w_ddone;
    logic signed [31:0] w_dq;
    logic               w_acc;

    akf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_noise (w_noise)
    );

    akf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    akf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (r_dsel ? r_w10 : r_w00),
        .i_den   (w_s[31:0]),
        .o_done  (w_ddone),
        .o_q     (w_dq)
    );

    assign i_in.ready           = (r_state == ST_IDLE);
    assign w_acc                = i_in.valid && i_in.ready;
    assign o_out.valid          = (r_state == ST_OUT);
    assign o_out.angle_estimate = r_ang;
    assign o_out.corrected_rate = r_rate;
    assign w_dstart             = (r_state == ST_DGO);

    // Product in the wide format and its two scalings.
    assign w_pw   = {{3{w_p[68]}}, w_p};
    assign w_sh16 = w_pw >>> 16;
    assign w_sh30 = w_pw >>> 30;

    // Angle covariance growth term, from the covariance before this word.
    assign w_inner = $signed({{4{r_dtp11[31]}}, r_dtp11})
                   - $signed({{4{r_cov01[31]}}, r_cov01})
                   - $signed({{4{r_cov10[31]}}, r_cov10})
                   + $signed({5'd0, w_noise.q_angle});

    // Innovation variance and its sign test.
    assign w_s     = $signed({{2{r_w00[31]}}, r_w00}) + $signed({3'd0, w_noise.r_meas});
    assign w_s_pos = !w_s[33] && (w_s != 34'sd0);

    // Operand select for each multiply step.
    always_comb begin
        case (r_step)
            4'd0: begin
                w_a = {{4{r_rate[31]}}, r_rate};
                w_b = {17'd0, r_dt};
            end
            4'd1: begin
                w_a = {{4{r_cov11[31]}}, r_cov11};
                w_b = {17'd0, r_dt};
            end
            4'd2: begin
                w_a = w_inner;
                w_b = {17'd0, r_dt};
            end
            4'd3: begin
                w_a = {5'd0, w_noise.q_bias};
                w_b = {17'd0, r_dt};
            end
            4'd4: begin
                w_a = {{4{r_k0[31]}}, r_k0};
                w_b = {r_y[31], r_y};
            end
            4'd5: begin
                w_a = {{4{r_k1[31]}}, r_k1};
                w_b = {r_y[31], r_y};
            end
            4'd6: begin
                w_a = {{4{r_k0[31]}}, r_k0};
                w_b = {r_w00[31], r_w00};
            end
            4'd7: begin
                w_a = {{4{r_k0[31]}}, r_k0};
                w_b = {r_w01[31], r_w01};
            end
            4'd8: begin
                w_a = {{4{r_k1[31]}}, r_k1};
                w_b = {r_w00[31], r_w00};
            end
            4'd9: begin
                w_a = {{4{r_k1[31]}}, r_k1};
                w_b = {r_w01[31], r_w01};
            end
            default: begin
                w_a = 36'sd0;
                w_b = 33'sd0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_acc) n_state = ST_MUL;
            ST_MUL:   n_state = ST_WB;
            ST_WB: begin
                if (r_step == 4'd3) begin
                    n_state = w_s_pos ? ST_DGO : ST_MUL;
                end else if (r_step == 4'd9) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DGO:   n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (w_ddone) n_state = r_dsel ? ST_MUL : ST_DGO;
            end
            ST_OUT:   if (o_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 4'd0;
            r_dsel  <= 1'b0;
            r_ang   <= 32'd0;
            r_bias  <= 32'd0;
            r_cov00 <= 32'd0;
            r_cov01 <= 32'd0;
            r_cov10 <= 32'd0;
            r_cov11 <= 32'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_step <= 4'd0;
                    r_dsel <= 1'b0;
                end
                ST_WB: begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd0: r_ang   <= akf_pkg::sat32(akf_pkg::sx72(r_ang) + w_sh16);
                        4'd4: r_ang   <= akf_pkg::sat32(akf_pkg::sx72(r_ang) + w_sh30);
                        4'd5: r_bias  <= akf_pkg::sat32(akf_pkg::sx72(r_bias) + w_sh30);
                        4'd6: r_cov00 <= akf_pkg::sat32(akf_pkg::sx72(r_w00) - w_sh30);
                        4'd7: r_cov01 <= akf_pkg::sat32(akf_pkg::sx72(r_w01) - w_sh30);
                        4'd8: r_cov10 <= akf_pkg::sat32(akf_pkg::sx72(r_w10) - w_sh30);
                        4'd9: r_cov11 <= akf_pkg::sat32(akf_pkg::sx72(r_w11) - w_sh30);
                        default: ;
                    endcase
                end
                ST_DWAIT: begin
                    if (w_ddone) r_dsel <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Working values of the current word.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_z    <= i_in.measured_angle;
            r_dt   <= i_in.time_step;
            r_rate <= akf_pkg::sat32(akf_pkg::sx72(i_in.measured_rate)
                                     - akf_pkg::sx72(r_bias));
        end
        if (r_state == ST_WB) begin
            case (r_step)
                4'd1: begin
                    r_dtp11 <= w_sh16[31:0];
                    r_w01   <= akf_pkg::sat32(akf_pkg::sx72(r_cov01) - w_sh16);
                    r_w10   <= akf_pkg::sat32(akf_pkg::sx72(r_cov10) - w_sh16);
                end
                4'd2: r_w00 <= akf_pkg::sat32(akf_pkg::sx72(r_cov00) + w_sh16);
                4'd3: begin
                    r_w11 <= akf_pkg::sat32(akf_pkg::sx72(r_cov11) + w_sh16);
                    r_y   <= akf_pkg::sat32(akf_pkg::sx72(r_z) - akf_pkg::sx72(r_ang));
                    // Gains stay zero unless the division runs.
                    r_k0  <= 32'd0;
                    r_k1  <= 32'd0;
                end
                default: ;
            endcase
        end
        if (r_state == ST_DWAIT && w_ddone) begin
            if (r_dsel) begin
                r_k1 <= w_dq;
            end else begin
                r_k0 <= w_dq;
            end
        end
    end

endmodule
